// File: rtl/sfd_pkg.sv
// Shared types and constants for the searchable queue with filtered delete.
// No dependencies; sfd_front, sfd_back and the top level import it.
package sfd_pkg;

  localparam logic [3:0] CMD_PUSH   = 4'd0;
  localparam logic [3:0] CMD_POP    = 4'd1;
  localparam logic [3:0] CMD_PEEK   = 4'd2;
  localparam logic [3:0] CMD_READ   = 4'd3;
  localparam logic [3:0] CMD_FIND   = 4'd4;
  localparam logic [3:0] CMD_DELEQ  = 4'd5;
  localparam logic [3:0] CMD_DELRNG = 4'd6;
  localparam logic [3:0] CMD_DEDUP  = 4'd7;
  localparam logic [3:0] CMD_SUM    = 4'd8;
  localparam logic [3:0] CMD_MIN    = 4'd9;
  localparam logic [3:0] CMD_MAX    = 4'd10;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef enum logic [3:0] {
    OP_PUSH, OP_POP, OP_PEEK, OP_READ, OP_FIND, OP_DEL,
    OP_DEDUP, OP_SUM, OP_MIN, OP_MAX, OP_NOP
  } op_t;

  // Decoded request; del_equal is carried as a range with lo == hi.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [5:0]         position;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_RD, S_EV, S_DUP_RD, S_DUP_EV, S_DONE
  } state_t;

endpackage

// File: rtl/sfd_req_if.sv
// Request channel: valid/ready handshake with command payload.
// No dependencies.
interface sfd_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic signed [31:0] operand_value;
  logic signed [31:0] range_high;
  logic [5:0]         position;

  modport source (output valid, cmd, operand_value, range_high, position, input ready);
  modport sink (input valid, cmd, operand_value, range_high, position, output ready);
endinterface

// File: rtl/sfd_rsp_if.sv
// Result channel: valid/ready handshake with status, value and occupancy.
// No dependencies.
interface sfd_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic [6:0]         occupancy;

  modport source (output valid, status, result_value, occupancy, input ready);
  modport sink (input valid, status, result_value, occupancy, output ready);
endinterface

// File: rtl/sfd_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
// Depends on sfd_pkg and sfd_req_if.
module sfd_front import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sfd_req_if.sink    req,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_take
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  job_t       decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.lo       = req.operand_value;
    decoded.hi       = req.range_high;
    decoded.position = req.position;
    case (req.cmd)
      CMD_PUSH:   decoded.op = OP_PUSH;
      CMD_POP:    decoded.op = OP_POP;
      CMD_PEEK:   decoded.op = OP_PEEK;
      CMD_READ:   decoded.op = OP_READ;
      CMD_FIND:   decoded.op = OP_FIND;
      CMD_DELEQ: begin
        decoded.op = OP_DEL;
        decoded.hi = req.operand_value;
      end
      CMD_DELRNG: decoded.op = OP_DEL;
      CMD_DEDUP:  decoded.op = OP_DEDUP;
      CMD_SUM:    decoded.op = OP_SUM;
      CMD_MIN:    decoded.op = OP_MIN;
      CMD_MAX:    decoded.op = OP_MAX;
      default:    decoded.op = OP_NOP;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = job_take && job_valid;
  assign job_valid = (fill != 2'd0);
  assign job       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/sfd_back.sv
// Back end: entry memory (circular buffer) and the sequencer that executes jobs.
// Depends on sfd_pkg and sfd_rsp_if.
module sfd_back import sfd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_take,
  sfd_rsp_if.source  rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  state_t             state, state_next;
  job_t               cur, cur_next;
  logic [CW-1:0]      count, count_next;
  logic [IW-1:0]      head, head_next;
  logic [CW-1:0]      r, r_next;
  logic [CW-1:0]      w, w_next;
  logic [CW-1:0]      k, k_next;
  logic signed [31:0] cand, cand_next;
  logic [2:0]         status, status_next;
  logic signed [31:0] value, value_next;
  logic               out_valid, out_valid_next;
  logic [2:0]         out_status, out_status_next;
  logic signed [31:0] out_value, out_value_next;
  logic [6:0]         out_occ, out_occ_next;

  logic               last;
  logic               dup_last;
  logic               keep;
  logic               out_free;
  logic               pos_bad;
  logic [31:0]        count_ext;

  // Logical index from the head to a memory address, wrapping at DEPTH.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(idx);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  assign last      = (r + CW'(1) == count);
  assign dup_last  = (k + CW'(1) == w);
  assign keep      = !((rdata >= cur.lo) && (rdata <= cur.hi));
  assign out_free  = !out_valid || rsp.ready;
  assign pos_bad   = (32'(cur.position) >= 32'(count));
  assign count_ext = 32'(count_next);
  assign job_take  = (state == S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (job_valid) state_next = S_START;
      S_START: begin
        case (cur.op)
          OP_PUSH, OP_NOP: state_next = S_DONE;
          OP_READ:         state_next = pos_bad ? S_DONE : S_RD;
          default:         state_next = (count == '0) ? S_DONE : S_RD;
        endcase
      end
      S_RD: state_next = S_EV;
      S_EV: begin
        case (cur.op)
          OP_POP, OP_PEEK, OP_READ: state_next = S_DONE;
          OP_FIND: state_next = ((rdata == cur.lo) || last) ? S_DONE : S_RD;
          OP_DEDUP: begin
            if (w != '0)   state_next = S_DUP_RD;
            else if (last) state_next = S_DONE;
            else           state_next = S_RD;
          end
          default: state_next = last ? S_DONE : S_RD;
        endcase
      end
      S_DUP_RD: state_next = S_DUP_EV;
      S_DUP_EV: begin
        if ((rdata == cand) || dup_last) state_next = last ? S_DONE : S_RD;
        else                             state_next = S_DUP_RD;
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cur_next        = cur;
    count_next      = count;
    head_next       = head;
    r_next          = r;
    w_next          = w;
    k_next          = k;
    cand_next       = cand;
    status_next     = status;
    value_next      = value;
    rd_en           = 1'b0;
    rd_addr         = phys(head, r);
    wr_en           = 1'b0;
    wr_addr         = phys(head, w);
    wr_data         = cand;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_occ_next    = out_occ;
    case (state)
      S_IDLE: if (job_valid) cur_next = job;
      S_START: begin
        status_next = ST_OK;
        value_next  = '0;
        r_next      = '0;
        w_next      = '0;
        case (cur.op)
          OP_PUSH: begin
            if (count >= CW'(DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = phys(head, count);
              wr_data    = cur.lo;
              count_next = count + CW'(1);
            end
          end
          OP_POP, OP_PEEK, OP_MIN, OP_MAX:
            if (count == '0) status_next = ST_EMPTY;
          OP_READ: begin
            if (pos_bad) status_next = ST_RANGE;
            else         r_next = CW'(cur.position);
          end
          OP_FIND: begin
            if (count == '0) begin
              status_next = ST_MISSING;
              value_next  = -32'sd1;
            end
          end
          default: ;
        endcase
      end
      S_RD: rd_en = 1'b1;
      S_EV: begin
        case (cur.op)
          OP_POP: begin
            value_next = rdata;
            head_next  = phys(head, CW'(1));
            count_next = count - CW'(1);
          end
          OP_PEEK, OP_READ: value_next = rdata;
          OP_FIND: begin
            if (rdata == cur.lo) begin
              value_next = 32'(r);
            end else if (last) begin
              status_next = ST_MISSING;
              value_next  = -32'sd1;
            end else begin
              r_next = r + CW'(1);
            end
          end
          OP_DEL: begin
            wr_data = rdata;
            if (keep) begin
              wr_en  = 1'b1;
              w_next = w + CW'(1);
            end
            r_next = r + CW'(1);
            if (last) count_next = w_next;
          end
          OP_SUM: begin
            value_next = value + rdata;
            r_next     = r + CW'(1);
          end
          OP_MIN, OP_MAX: begin
            if ((r == '0) || ((cur.op == OP_MIN) && (rdata < value)) ||
                ((cur.op == OP_MAX) && (rdata > value))) begin
              value_next = rdata;
            end
            r_next = r + CW'(1);
          end
          OP_DEDUP: begin
            cand_next = rdata;
            k_next    = '0;
            if (w == '0) begin
              // first entry is always kept
              wr_en   = 1'b1;
              wr_data = rdata;
              w_next  = CW'(1);
              r_next  = r + CW'(1);
              if (last) count_next = CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_DUP_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, k);
      end
      S_DUP_EV: begin
        if (rdata == cand) begin
          r_next = r + CW'(1);
          if (last) count_next = w;
        end else if (dup_last) begin
          wr_en  = 1'b1;
          w_next = w + CW'(1);
          r_next = r + CW'(1);
          if (last) count_next = w_next;
        end else begin
          k_next = k + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = status;
          out_value_next  = value;
          out_occ_next    = count_ext[6:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    r          <= r_next;
    w          <= w_next;
    k          <= k_next;
    cand       <= cand_next;
    status     <= status_next;
    value      <= value_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_occ    <= out_occ_next;
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_value = out_value;
  assign rsp.occupancy    = out_occ;

endmodule

// File: rtl/searchable_fifo_with_filtered_delete_unit.sv
// Top level of the searchable queue with filtered delete.
// Depends on sfd_pkg, sfd_req_if, sfd_rsp_if, sfd_front and sfd_back.
//
// Usage:
//   req  - request channel (valid/ready). A request is taken when valid and
//          ready are both high. Fields: cmd, operand_value, range_high,
//          position.
//   rsp  - result channel (valid/ready). One result per request, in order:
//          status, result_value and occupancy after the command.
// Work per request once the back end picks it up:
//   push, no-op and any early error:   no memory read, straight to done
//   pop, peek, read_at:                one entry read
//   find, sum, min, max, deletes:      a read and evaluate per stored entry (find stops at a match)
//   dedup:                             as above, and each entry is also compared with the kept ones
// The loop is paced by the single read port of the entry memory, whose
// read is registered, so each visited entry takes a read and an evaluate state.
// The front end queues two decoded requests, so requests keep being taken
// while the back end works or a result waits on a stalled receiver, until both slots fill.
// A stalled receiver holds the result register; the back end then waits
// in its done state. Reset empties the queue, the request buffer and the
// result register; memory contents are not cleared and need no sweep.
module searchable_fifo_with_filtered_delete_unit import sfd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic     clk,
  input logic     rst,
  sfd_req_if.sink req,
  sfd_rsp_if.source rsp
);

  logic job_valid;
  job_t job;
  logic job_take;

  // Accept and decode; del_equal becomes a range with equal bounds.
  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Execute against the circular entry memory and register the result.
  sfd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .rsp       (rsp)
  );

endmodule
